// ===== hdl/oriented_box_pair_contact_defines.svh =====
// Assertion macros for the oriented box pair contact block.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ORIENTED_BOX_PAIR_CONTACT_DEFINES_SVH
`define ORIENTED_BOX_PAIR_CONTACT_DEFINES_SVH

`define OBPC_CHECK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oriented box pair contact check failed");

`define OBPC_CHECK_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("oriented box pair contact check failed");

`endif

// ===== hdl/obpc_pkg.sv =====
// Types, constants and helpers for the oriented box pair contact block.
// No dependencies; used by oriented_box_pair_contact.
package obpc_pkg;

  localparam int NSTG  = 7;
  localparam int NCAND = 8;

  localparam logic [14:0] THR_RESET = 15'd16302;
  localparam logic signed [16:0] NORM_MAX = 17'sd16384;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic [30:0]        w;
    logic [30:0]        h;
  } box_t;

  typedef struct packed {
    logic               vld;
    logic               swp;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [30:0]        pen;
  } cand_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_norm(input logic signed [16:0] v);
    logic signed [16:0] r;
    if (v > NORM_MAX) begin
      r = NORM_MAX;
    end else if (v < -NORM_MAX) begin
      r = -NORM_MAX;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

  // True when a (earlier in scan order) wins the least-penetration choice over b.
  function automatic logic pick_first(input cand_t a, input cand_t b);
    return a.vld && (!b.vld || a.pen <= b.pen);
  endfunction

endpackage

// ===== hdl/oriented_box_pair_contact.sv =====
// Top level of the oriented box pair contact block: a seven-stage pipeline.
// Depends on obpc_pkg and oriented_box_pair_contact_defines.svh.
//
// The block takes one pair of oriented boxes per beat on the in_ channel and
// returns exactly one contact result per pair on the out_ channel, in order.
// A beat moves on a channel at a rising edge where valid is high and stall is
// low. The cfg_ channel writes the merge cosine threshold; cfg_ready is always
// high and writes are expected only while the pipeline is empty.
// Throughput is one pair per cycle while the receiver does not stall. Each
// pair passes through the seven register stages in turn: difference products,
// rotated offsets and world corners, corner rotation products, local corners,
// face choice, normal dot products with penetration minimum, and the final
// merge selection in the output register.
// Each stage holds its data while the stage after it is full and blocked, so
// empty stages still fill while the receiver stalls; in_stall rises only when
// all seven stages hold results. Synchronous reset empties the pipeline and
// restores the threshold to its reset value.
`include "oriented_box_pair_contact_defines.svh"

module oriented_box_pair_contact (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_a_pos_x,
  input  logic signed [31:0] in_a_pos_y,
  input  logic signed [15:0] in_a_cos,
  input  logic signed [15:0] in_a_sin,
  input  logic [30:0]        in_a_width,
  input  logic [30:0]        in_a_height,
  input  logic signed [31:0] in_b_pos_x,
  input  logic signed [31:0] in_b_pos_y,
  input  logic signed [15:0] in_b_cos,
  input  logic signed [15:0] in_b_sin,
  input  logic [30:0]        in_b_width,
  input  logic [30:0]        in_b_height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic               out_bodies_swapped,
  output logic [1:0]         out_contact_count,
  output logic signed [31:0] out_contact0_x,
  output logic signed [31:0] out_contact0_y,
  output logic signed [31:0] out_contact1_x,
  output logic signed [31:0] out_contact1_y,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic [30:0]        out_penetration
);

  localparam int NS = obpc_pkg::NSTG;
  localparam int NC = obpc_pkg::NCAND;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] blk;
  logic [NS-1:0] ld;
  logic [14:0]   thr_r;

  // Stage 1
  obpc_pkg::box_t     bx_in [2];
  obpc_pkg::box_t     b1_r [2];
  logic signed [48:0] cdx1_r [2], sdy1_r [2], cdy1_r [2], sdx1_r [2];
  logic signed [48:0] cdx1_nxt [2], sdy1_nxt [2], cdy1_nxt [2], sdx1_nxt [2];
  logic signed [31:0] rcc1_r [2], rss1_r [2], rsc1_r [2], rcs1_r [2];
  logic signed [31:0] rcc1_nxt [2], rss1_nxt [2], rsc1_nxt [2], rcs1_nxt [2];
  logic signed [47:0] cw1_r [2], sh1_r [2], sw1_r [2], ch1_r [2];
  logic signed [47:0] cw1_nxt [2], sh1_nxt [2], sw1_nxt [2], ch1_nxt [2];

  // Stage 2
  obpc_pkg::box_t     b2_r [2];
  logic signed [50:0] tx2_r [2], ty2_r [2], tx2_nxt [2], ty2_nxt [2];
  logic signed [18:0] rc2_r [2], rs2_r [2], rc2_nxt [2], rs2_nxt [2];
  logic signed [31:0] wcx2_r [2][4], wcy2_r [2][4], wcx2_nxt [2][4], wcy2_nxt [2][4];

  // Stage 3
  obpc_pkg::box_t     b3_r [2];
  logic signed [50:0] tx3_r [2], ty3_r [2];
  logic signed [50:0] rcw3_r [2], rsh3_r [2], rsw3_r [2], rch3_r [2];
  logic signed [50:0] rcw3_nxt [2], rsh3_nxt [2], rsw3_nxt [2], rch3_nxt [2];
  logic signed [31:0] wcx3_r [2][4], wcy3_r [2][4];

  // Stage 4
  obpc_pkg::box_t     b4_r [2];
  logic signed [39:0] ux4_r [2][4], uy4_r [2][4], ux4_nxt [2][4], uy4_nxt [2][4];
  logic signed [31:0] wcx4_r [2][4], wcy4_r [2][4];

  // Stage 5
  obpc_pkg::cand_t    cand5_r [NC], cand5_nxt [NC];

  // Stage 6
  obpc_pkg::cand_t    cand6_r [NC];
  logic               mrg6_r [NC][NC], mrg6_nxt [NC][NC];
  logic [2:0]         bst6_r [2], bst6_nxt [2];

  // Stage 7 (output register)
  logic               hit7_nxt, swp7_nxt;
  logic [1:0]         cnt7_nxt;
  logic signed [31:0] c0x7_nxt, c0y7_nxt, c1x7_nxt, c1y7_nxt;
  logic signed [15:0] nx7_nxt, ny7_nxt;
  logic [30:0]        pen7_nxt;

  // Flow control: a stage loads when it is empty or the stage after it moves.
  always_comb begin
    blk[NS-1] = out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      blk[s] = vld_r[s+1] & blk[s+1];
    end
    for (int s = 0; s < NS; s++) begin
      ld[s] = !(vld_r[s] & blk[s]);
    end
  end

  assign in_stall  = vld_r[0] & blk[0];
  assign out_valid = vld_r[NS-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= obpc_pkg::THR_RESET;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (ld[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // Stage 1: centre differences and trig products.
  always_comb begin
    obpc_pkg::box_t     f;
    obpc_pkg::box_t     o;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] wl;
    logic signed [31:0] hl;
    bx_in[0] = '{px: in_a_pos_x, py: in_a_pos_y, c: in_a_cos, s: in_a_sin,
                 w: in_a_width, h: in_a_height};
    bx_in[1] = '{px: in_b_pos_x, py: in_b_pos_y, c: in_b_cos, s: in_b_sin,
                 w: in_b_width, h: in_b_height};
    for (int d = 0; d < 2; d++) begin
      f  = bx_in[d];
      o  = bx_in[1-d];
      dx = 33'(o.px) - 33'(f.px);
      dy = 33'(o.py) - 33'(f.py);
      cdx1_nxt[d] = f.c * dx;
      sdy1_nxt[d] = f.s * dy;
      cdy1_nxt[d] = f.c * dy;
      sdx1_nxt[d] = f.s * dx;
      rcc1_nxt[d] = o.c * f.c;
      rss1_nxt[d] = o.s * f.s;
      rsc1_nxt[d] = o.s * f.c;
      rcs1_nxt[d] = o.c * f.s;
      wl = $signed({1'b0, f.w});
      hl = $signed({1'b0, f.h});
      cw1_nxt[d] = f.c * wl;
      sh1_nxt[d] = f.s * hl;
      sw1_nxt[d] = f.s * wl;
      ch1_nxt[d] = f.c * hl;
    end
  end

  // Stage 2: frame offsets, rotation difference and world corners.
  always_comb begin
    logic signed [49:0] t;
    logic signed [32:0] q;
    logic signed [49:0] e;
    logic signed [34:0] off;
    for (int d = 0; d < 2; d++) begin
      t = 50'(cdx1_r[d]) + 50'(sdy1_r[d]);
      tx2_nxt[d] = $signed({t, 1'b0});
      t = 50'(cdy1_r[d]) - 50'(sdx1_r[d]);
      ty2_nxt[d] = $signed({t, 1'b0});
      q = 33'(rcc1_r[d]) + 33'(rss1_r[d]) + 33'sd8192;
      rc2_nxt[d] = 19'(q >>> 14);
      q = 33'(rsc1_r[d]) - 33'(rcs1_r[d]) + 33'sd8192;
      rs2_nxt[d] = 19'(q >>> 14);
      for (int k = 0; k < 4; k++) begin
        e = ((k < 2) ? 50'(cw1_r[d]) : -50'(cw1_r[d]))
          + (((k % 2) == 0) ? -50'(sh1_r[d]) : 50'(sh1_r[d])) + 50'sd16384;
        off = 35'(e >>> 15);
        wcx2_nxt[d][k] = obpc_pkg::sat32(36'(b1_r[d].px) + 36'(off));
        e = ((k < 2) ? 50'(sw1_r[d]) : -50'(sw1_r[d]))
          + (((k % 2) == 0) ? 50'(ch1_r[d]) : -50'(ch1_r[d])) + 50'sd16384;
        off = 35'(e >>> 15);
        wcy2_nxt[d][k] = obpc_pkg::sat32(36'(b1_r[d].py) + 36'(off));
      end
    end
  end

  // Stage 3: rotation difference times the other box's width and height.
  always_comb begin
    logic signed [31:0] wo;
    logic signed [31:0] ho;
    for (int d = 0; d < 2; d++) begin
      wo = $signed({1'b0, b2_r[1-d].w});
      ho = $signed({1'b0, b2_r[1-d].h});
      rcw3_nxt[d] = rc2_r[d] * wo;
      rsh3_nxt[d] = rs2_r[d] * ho;
      rsw3_nxt[d] = rs2_r[d] * wo;
      rch3_nxt[d] = rc2_r[d] * ho;
    end
  end

  // Stage 4: doubled local corner coordinates in the host frame.
  always_comb begin
    logic signed [53:0] e;
    for (int d = 0; d < 2; d++) begin
      for (int k = 0; k < 4; k++) begin
        e = 54'(tx3_r[d]) + ((k < 2) ? 54'(rcw3_r[d]) : -54'(rcw3_r[d]))
          + (((k % 2) == 0) ? -54'(rsh3_r[d]) : 54'(rsh3_r[d])) + 54'sd8192;
        ux4_nxt[d][k] = 40'(e >>> 14);
        e = 54'(ty3_r[d]) + ((k < 2) ? 54'(rsw3_r[d]) : -54'(rsw3_r[d]))
          + (((k % 2) == 0) ? 54'(rch3_r[d]) : -54'(rch3_r[d])) + 54'sd8192;
        uy4_nxt[d][k] = 40'(e >>> 14);
      end
    end
  end

  // Stage 5: inside test, nearer face, normal and penetration.
  always_comb begin
    logic signed [40:0] hw;
    logic signed [40:0] hh;
    logic signed [40:0] ux;
    logic signed [40:0] uy;
    logic signed [40:0] bxv;
    logic signed [40:0] byv;
    logic signed [40:0] pen;
    logic signed [40:0] pr;
    logic signed [16:0] cc;
    logic signed [16:0] ss;
    logic signed [16:0] nx;
    logic signed [16:0] ny;
    for (int d = 0; d < 2; d++) begin
      for (int k = 0; k < 4; k++) begin
        hw  = $signed({10'd0, b4_r[d].w});
        hh  = $signed({10'd0, b4_r[d].h});
        ux  = 41'(ux4_r[d][k]);
        uy  = 41'(uy4_r[d][k]);
        cc  = 17'(b4_r[d].c);
        ss  = 17'(b4_r[d].s);
        bxv = (hw - ux < ux + hw) ? hw - ux : ux + hw;
        byv = (hh - uy < uy + hh) ? hh - uy : uy + hh;
        if (byv > bxv) begin
          pen = bxv;
          nx  = (ux < 0) ? -cc : cc;
          ny  = (ux < 0) ? -ss : ss;
        end else begin
          pen = byv;
          nx  = (uy < 0) ? ss : -ss;
          ny  = (uy < 0) ? -cc : cc;
        end
        if (d == 1) begin
          nx = -nx;
          ny = -ny;
        end
        pr = (pen + 41'sd1) >>> 1;
        cand5_nxt[d*4+k].vld = (ux < hw) && (ux > -hw) && (uy < hh) && (uy > -hh);
        cand5_nxt[d*4+k].swp = (d == 1);
        cand5_nxt[d*4+k].cx  = wcx4_r[1-d][k];
        cand5_nxt[d*4+k].cy  = wcy4_r[1-d][k];
        cand5_nxt[d*4+k].nx  = obpc_pkg::sat_norm(nx);
        cand5_nxt[d*4+k].ny  = obpc_pkg::sat_norm(ny);
        cand5_nxt[d*4+k].pen = pr[30:0];
      end
    end
  end

  // Stage 6: pairwise normal agreement and the first two levels of the minimum.
  always_comb begin
    logic signed [31:0] dp;
    logic signed [31:0] thr;
    logic [2:0]         w [4];
    thr = $signed({3'd0, thr_r, 14'd0});
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        dp = 32'(cand5_r[i].nx * cand5_r[j].nx) + 32'(cand5_r[i].ny * cand5_r[j].ny);
        mrg6_nxt[i][j] = (j > i) && cand5_r[i].vld && cand5_r[j].vld && (dp > thr);
      end
    end
    for (int p = 0; p < 4; p++) begin
      w[p] = obpc_pkg::pick_first(cand5_r[2*p], cand5_r[2*p+1]) ? 3'(2*p) : 3'(2*p+1);
    end
    bst6_nxt[0] = obpc_pkg::pick_first(cand5_r[w[0]], cand5_r[w[1]]) ? w[0] : w[1];
    bst6_nxt[1] = obpc_pkg::pick_first(cand5_r[w[2]], cand5_r[w[3]]) ? w[2] : w[3];
  end

  // Stage 7: earliest mergeable pair, else least penetration.
  always_comb begin
    logic       found;
    logic [2:0] mi;
    logic [2:0] mj;
    logic [2:0] bst;
    logic [2:0] sel;
    found = 1'b0;
    mi    = '0;
    mj    = '0;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        if (!found && mrg6_r[i][j]) begin
          found = 1'b1;
          mi    = 3'(i);
          mj    = 3'(j);
        end
      end
    end
    bst = obpc_pkg::pick_first(cand6_r[bst6_r[0]], cand6_r[bst6_r[1]]) ?
          bst6_r[0] : bst6_r[1];
    sel = found ? mi : bst;
    hit7_nxt = found || cand6_r[bst].vld;
    swp7_nxt = '0;
    cnt7_nxt = 2'd0;
    c0x7_nxt = '0;
    c0y7_nxt = '0;
    c1x7_nxt = '0;
    c1y7_nxt = '0;
    nx7_nxt  = '0;
    ny7_nxt  = '0;
    pen7_nxt = '0;
    if (hit7_nxt) begin
      swp7_nxt = cand6_r[sel].swp;
      cnt7_nxt = found ? 2'd2 : 2'd1;
      c0x7_nxt = cand6_r[sel].cx;
      c0y7_nxt = cand6_r[sel].cy;
      nx7_nxt  = cand6_r[sel].nx;
      ny7_nxt  = cand6_r[sel].ny;
      pen7_nxt = cand6_r[sel].pen;
      if (found) begin
        c1x7_nxt = cand6_r[mj].cx;
        c1y7_nxt = cand6_r[mj].cy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      b1_r   <= bx_in;
      cdx1_r <= cdx1_nxt;
      sdy1_r <= sdy1_nxt;
      cdy1_r <= cdy1_nxt;
      sdx1_r <= sdx1_nxt;
      rcc1_r <= rcc1_nxt;
      rss1_r <= rss1_nxt;
      rsc1_r <= rsc1_nxt;
      rcs1_r <= rcs1_nxt;
      cw1_r  <= cw1_nxt;
      sh1_r  <= sh1_nxt;
      sw1_r  <= sw1_nxt;
      ch1_r  <= ch1_nxt;
    end
    if (ld[1]) begin
      b2_r   <= b1_r;
      tx2_r  <= tx2_nxt;
      ty2_r  <= ty2_nxt;
      rc2_r  <= rc2_nxt;
      rs2_r  <= rs2_nxt;
      wcx2_r <= wcx2_nxt;
      wcy2_r <= wcy2_nxt;
    end
    if (ld[2]) begin
      b3_r   <= b2_r;
      tx3_r  <= tx2_r;
      ty3_r  <= ty2_r;
      rcw3_r <= rcw3_nxt;
      rsh3_r <= rsh3_nxt;
      rsw3_r <= rsw3_nxt;
      rch3_r <= rch3_nxt;
      wcx3_r <= wcx2_r;
      wcy3_r <= wcy2_r;
    end
    if (ld[3]) begin
      b4_r   <= b3_r;
      ux4_r  <= ux4_nxt;
      uy4_r  <= uy4_nxt;
      wcx4_r <= wcx3_r;
      wcy4_r <= wcy3_r;
    end
    if (ld[4]) begin
      cand5_r <= cand5_nxt;
    end
    if (ld[5]) begin
      cand6_r <= cand5_r;
      mrg6_r  <= mrg6_nxt;
      bst6_r  <= bst6_nxt;
    end
    if (ld[6]) begin
      out_hit            <= hit7_nxt;
      out_bodies_swapped <= swp7_nxt;
      out_contact_count  <= cnt7_nxt;
      out_contact0_x     <= c0x7_nxt;
      out_contact0_y     <= c0y7_nxt;
      out_contact1_x     <= c1x7_nxt;
      out_contact1_y     <= c1y7_nxt;
      out_normal_x       <= nx7_nxt;
      out_normal_y       <= ny7_nxt;
      out_penetration    <= pen7_nxt;
    end
  end

  `OBPC_CHECK_IMPL(a_nohit_zero, out_valid && !out_hit, out_contact_count == 2'd0 && out_penetration == 31'd0)
  `OBPC_CHECK_IMPL(a_hit_count, out_valid && out_hit, out_contact_count != 2'd0)
  `OBPC_CHECK_IMPL(a_single_point, out_valid && out_contact_count == 2'd1, out_contact1_x == 32'sd0 && out_contact1_y == 32'sd0)
  `OBPC_CHECK_IMPL(a_normal_range, out_valid, out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384)
  `OBPC_CHECK_IMPL(a_stall_source, in_stall, out_stall && out_valid)
  `OBPC_CHECK_NEVER(a_count_code, out_valid && out_contact_count == 2'd3)

endmodule

// ===== tb/oriented_box_pair_contact_checker.sv =====
// Checker for the oriented box pair contact block: watches the input, result and
// configuration channels, predicts each contact result and compares it field by field.
// Depends on nothing beyond the block's port widths.
`timescale 1ns / 1ps

module oriented_box_pair_contact_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_a_pos_x,
  input  logic signed [31:0] in_a_pos_y,
  input  logic signed [15:0] in_a_cos,
  input  logic signed [15:0] in_a_sin,
  input  logic [30:0]        in_a_width,
  input  logic [30:0]        in_a_height,
  input  logic signed [31:0] in_b_pos_x,
  input  logic signed [31:0] in_b_pos_y,
  input  logic signed [15:0] in_b_cos,
  input  logic signed [15:0] in_b_sin,
  input  logic [30:0]        in_b_width,
  input  logic [30:0]        in_b_height,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic               out_bodies_swapped,
  input  logic [1:0]         out_contact_count,
  input  logic signed [31:0] out_contact0_x,
  input  logic signed [31:0] out_contact0_y,
  input  logic signed [31:0] out_contact1_x,
  input  logic signed [31:0] out_contact1_y,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic [30:0]        out_penetration,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    longint px, py, c, s, w, h;
  } shape_t;

  typedef struct {
    bit     swp;
    longint cx, cy, nx, ny, pen;
  } corner_hit_t;

  typedef struct {
    bit          hit;
    bit          swp;
    logic [1:0]  cnt;
    logic [31:0] c0x, c0y, c1x, c1y;
    logic [15:0] nx, ny;
    logic [30:0] pen;
  } contact_t;

  contact_t    contacts_due[$];
  logic [14:0] merge_thr;
  corner_hit_t hits[$];

  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  task automatic probe_corners(shape_t f, shape_t o, bit swp);
    longint dx, dy, tx, ty, rc, rs, ex, ey, ux, uy, bx, by, lx, ly, pn, nx, ny;
    corner_hit_t ch;
    dx = o.px - f.px;
    dy = o.py - f.py;
    tx = 2 * (f.c * dx + f.s * dy);
    ty = 2 * (f.c * dy - f.s * dx);
    rc = round_shift(o.c * f.c + o.s * f.s, 14);
    rs = round_shift(o.s * f.c - o.c * f.s, 14);
    for (int k = 0; k < 4; k++) begin
      ex = (k < 2) ? o.w : -o.w;
      ey = (k & 1) ? -o.h : o.h;
      ux = round_shift(tx + rc * ex - rs * ey, 14);
      uy = round_shift(ty + rs * ex + rc * ey, 14);
      if (!(ux < f.w && ux > -f.w && uy < f.h && uy > -f.h)) continue;
      bx = (f.w - ux < ux + f.w) ? f.w - ux : ux + f.w;
      by = (f.h - uy < uy + f.h) ? f.h - uy : uy + f.h;
      if (by > bx) begin
        lx = (ux < 0) ? -1 : 1;
        ly = 0;
        pn = bx;
      end else begin
        lx = 0;
        ly = (uy < 0) ? -1 : 1;
        pn = by;
      end
      nx = f.c * lx - f.s * ly;
      ny = f.s * lx + f.c * ly;
      if (swp) begin
        nx = -nx;
        ny = -ny;
      end
      ch.swp = swp;
      ch.nx = clip(nx, -16384, 16384);
      ch.ny = clip(ny, -16384, 16384);
      ch.pen = (pn + 1) / 2;
      ch.cx = clip(o.px + round_shift(o.c * ex - o.s * ey, 15), -64'sd2147483648, 64'sd2147483647);
      ch.cy = clip(o.py + round_shift(o.s * ex + o.c * ey, 15), -64'sd2147483648, 64'sd2147483647);
      hits.push_back(ch);
    end
  endtask

  task automatic predict_contact();
    shape_t a, b;
    contact_t r;
    int best, mi, mj, s;
    longint thr;
    a = '{in_a_pos_x, in_a_pos_y, in_a_cos, in_a_sin, longint'(in_a_width),
          longint'(in_a_height)};
    b = '{in_b_pos_x, in_b_pos_y, in_b_cos, in_b_sin, longint'(in_b_width),
          longint'(in_b_height)};
    hits.delete();
    probe_corners(a, b, 1'b0);
    probe_corners(b, a, 1'b1);
    thr = longint'(merge_thr) * 16384;
    best = -1;
    mi = -1;
    mj = -1;
    for (int i = 0; i < hits.size() && mi < 0; i++) begin
      if (best < 0 || hits[i].pen < hits[best].pen) best = i;
      for (int j = i + 1; j < hits.size(); j++) begin
        if (hits[i].nx * hits[j].nx + hits[i].ny * hits[j].ny > thr) begin
          mi = i;
          mj = j;
          break;
        end
      end
    end
    r = '{default: 0};
    if (mi >= 0 || best >= 0) begin
      s = (mi >= 0) ? mi : best;
      r.hit = 1;
      r.swp = hits[s].swp;
      r.cnt = (mi >= 0) ? 2 : 1;
      r.c0x = hits[s].cx;
      r.c0y = hits[s].cy;
      if (mi >= 0) begin
        r.c1x = hits[mj].cx;
        r.c1y = hits[mj].cy;
      end
      r.nx = hits[s].nx;
      r.ny = hits[s].ny;
      r.pen = hits[s].pen;
    end
    contacts_due.push_back(r);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic compare_contact();
    contact_t e;
    if (contacts_due.size() == 0) begin
      report("unexpected beat", 1, 0);
    end else begin
      e = contacts_due.pop_front();
      if (out_hit !== e.hit) report("hit", out_hit, e.hit);
      if (out_bodies_swapped !== e.swp) report("bodies_swapped", out_bodies_swapped, e.swp);
      if (out_contact_count !== e.cnt) report("contact_count", out_contact_count, e.cnt);
      if (out_contact0_x !== e.c0x) report("contact0_x", out_contact0_x, e.c0x);
      if (out_contact0_y !== e.c0y) report("contact0_y", out_contact0_y, e.c0y);
      if (out_contact1_x !== e.c1x) report("contact1_x", out_contact1_x, e.c1x);
      if (out_contact1_y !== e.c1y) report("contact1_y", out_contact1_y, e.c1y);
      if (out_normal_x !== e.nx) report("normal_x", out_normal_x, e.nx);
      if (out_normal_y !== e.ny) report("normal_y", out_normal_y, e.ny);
      if (out_penetration !== e.pen) report("penetration", out_penetration, e.pen);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      merge_thr <= 15'd16302;
    end else begin
      if (out_valid && !out_stall) compare_contact();
      if (in_valid && !in_stall) predict_contact();
      if (cfg_valid && cfg_ready) merge_thr <= cfg_data;
    end
    pending = contacts_due.size();
  end

endmodule

// ===== tb/oriented_box_pair_contact_test.sv =====
// Top of the oriented box pair contact testbench: clock, reset, stimulus and verdict.
// Depends on oriented_box_pair_contact and oriented_box_pair_contact_checker.
`timescale 1ns / 1ps

module oriented_box_pair_contact_test;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] a_px = 0, a_py = 0, b_px = 0, b_py = 0;
  logic signed [15:0] a_c = 0, a_s = 0, b_c = 0, b_s = 0;
  logic [30:0]        a_w = 0, a_h = 0, b_w = 0, b_h = 0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [14:0]        cfg_data = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               hit, swp;
  logic [1:0]         cnt;
  logic signed [31:0] c0x, c0y, c1x, c1y;
  logic signed [15:0] nx, ny;
  logic [30:0]        pen;
  int                 errors, pending;
  bit                 calm = 0;
  int                 hold_off = 0;
  int                 stall_left = 0;

  localparam logic [15:0] ONE = 16'sd16384;
  localparam int          LATENCY = 7;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  oriented_box_pair_contact uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_pos_x(a_px), .in_a_pos_y(a_py), .in_a_cos(a_c), .in_a_sin(a_s),
    .in_a_width(a_w), .in_a_height(a_h), .in_b_pos_x(b_px), .in_b_pos_y(b_py),
    .in_b_cos(b_c), .in_b_sin(b_s), .in_b_width(b_w), .in_b_height(b_h),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(hit),
    .out_bodies_swapped(swp), .out_contact_count(cnt), .out_contact0_x(c0x),
    .out_contact0_y(c0y), .out_contact1_x(c1x), .out_contact1_y(c1y),
    .out_normal_x(nx), .out_normal_y(ny), .out_penetration(pen)
  );

  oriented_box_pair_contact_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_pos_x(a_px), .in_a_pos_y(a_py), .in_a_cos(a_c), .in_a_sin(a_s),
    .in_a_width(a_w), .in_a_height(a_h), .in_b_pos_x(b_px), .in_b_pos_y(b_py),
    .in_b_cos(b_c), .in_b_sin(b_s), .in_b_width(b_w), .in_b_height(b_h),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(hit),
    .out_bodies_swapped(swp), .out_contact_count(cnt), .out_contact0_x(c0x),
    .out_contact0_y(c0y), .out_contact1_x(c1x), .out_contact1_y(c1y),
    .out_normal_x(nx), .out_normal_y(ny), .out_penetration(pen),
    .errors(errors), .pending(pending)
  );

  // Receiver: random stall bursts, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (stall_left > 0 && !calm) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 0;
    end
  end

  function automatic logic signed [15:0] trig_value();
    case ($urandom_range(0, 5))
      0: return ONE;
      1: return -ONE;
      2: return 0;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  function automatic logic [30:0] size_value();
    case ($urandom_range(0, 9))
      0: return 31'h7FFFFFFF;
      1: return 0;
      2: return $urandom;
      default: return $urandom_range(1, 1 << 22);
    endcase
  endfunction

  task automatic send_pair(logic signed [31:0] apx, apy, logic signed [15:0] ac, as_,
                           logic [30:0] aw, ah, logic signed [31:0] bpx, bpy,
                           logic signed [15:0] bc, bs, logic [30:0] bw, bh);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1;
    a_px <= apx; a_py <= apy; a_c <= ac; a_s <= as_; a_w <= aw; a_h <= ah;
    b_px <= bpx; b_py <= bpy; b_c <= bc; b_s <= bs; b_w <= bw; b_h <= bh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic signed [31:0] apx, apy, off;
    apx = $urandom;
    apy = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      send_pair(apx, apy, trig_value(), trig_value(), size_value(), size_value(),
                $urandom, $urandom, trig_value(), trig_value(), size_value(), size_value());
    end else begin
      // Near pairs, so that corners overlap and the merge logic is reached.
      off = $urandom_range(0, 1 << 22);
      send_pair(apx, apy, trig_value(), trig_value(), size_value(), size_value(),
                apx + off - (1 << 21), apy + $urandom_range(0, 1 << 22) - (1 << 21),
                trig_value(), trig_value(), size_value(), size_value());
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_threshold(logic [14:0] thr);
    cfg_valid <= 1;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    logic [14:0] thresholds[5];
    thresholds = '{15'd16302, 15'd0, 15'd16384, 15'h7FFF, 15'd11585};
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: no hit, identical boxes, contained box, rotations, extremes.
    send_pair(0, 0, ONE, 0, 31'h20000, 31'h20000, 32'h7FFFFFFF, 0, ONE, 0, 31'h10000, 31'h10000);
    send_pair(0, 0, ONE, 0, 31'h40000, 31'h40000, 0, 0, ONE, 0, 31'h40000, 31'h40000);
    send_pair(0, 0, ONE, 0, 31'h40000, 31'h40000, 0, 0, ONE, 0, 31'h10000, 31'h10000);
    send_pair(0, 0, ONE, 0, 31'h10000, 31'h10000, 0, 0, ONE, 0, 31'h40000, 31'h40000);
    send_pair(0, 0, ONE, 0, 31'h40000, 31'h40000, 31'h18000, 0, 11585, 11585,
              31'h10000, 31'h10000);
    send_pair(0, 0, 0, ONE, 31'h40000, 31'h20000, 0, 31'h8000, -ONE, 0, 31'h10000, 31'h30000);
    send_pair(32'h7FFFFFF0, 32'h80000010, -ONE, 0, 31'h7FFFFFFF, 31'h7FFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 0, -ONE, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_pair(32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h8000, 31'h7FFFFFFF, 0,
              32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h7FFF, 0, 31'h7FFFFFFF);
    send_pair(0, 0, 16'hFFFF, 16'hFFFF, 31'h55555555, 31'h2AAAAAAA, 32'hFFFFFFFF,
              32'h55555555, 16'h5555, 16'hAAAA, 31'h2AAAAAAA, 31'h55555555);
    send_pair(100, -100, ONE, 0, 31'h30000, 31'h10000, 200, 50, 0, ONE, 31'h30000, 31'h10000);
    for (int p = 0; p < 5; p++) begin
      drain();
      write_threshold(thresholds[p]);
      for (int n = 0; n < 200; n++) send_random();
      if (p == 1) begin
        hold_off = 60;
        for (int n = 0; n < 30; n++) send_random();
      end
    end
    drain();
    write_threshold(15'd16302);
    calm = 1;
    for (int n = 0; n < 400; n++) send_random();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (errors == 0) begin
      $display("PASS oriented_box_pair_contact");
    end else begin
      $display("FAIL oriented_box_pair_contact");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL oriented_box_pair_contact");
    $finish;
  end

endmodule
